FILE: design/pez_pkg.sv
// Shared types and constants for the polygon exclusion zone tester.
// Used by pez_edge and the top level in the design folder; depends on nothing.
`timescale 1ns / 1ps

package pez_pkg;

  localparam int unsigned CoordW       = 32;
  localparam int unsigned TotalW       = 5;
  localparam int unsigned MinPolyVerts = 3;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_CLOSE  = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_VTX_FULL = 2'd1,
    ST_TBL_FULL = 2'd2,
    ST_DISCARD  = 2'd3
  } status_e;

  typedef struct packed {
    mode_e                    mode;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
  } in_t;

  typedef struct packed {
    logic        inside_res;
    status_e     status;
    logic [4:0]  polygon_total;
  } out_t;

  typedef struct packed {
    logic clear;
    logic issue;
    logic last;
  } edge_ctl_t;

  typedef struct packed {
    logic busy;
    logic hit;
  } edge_sts_t;

endpackage

FILE: design/pez_ram.sv
// Generic single-write, single-read memory with registered read data.
// Standalone; no package needed.
`timescale 1ns / 1ps

module pez_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 256
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                              wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                              rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: design/pez_edge.sv
// Edge crossing pipeline: differences, exact products, compare and parity.
// Depends on pez_pkg for the control and status structs.
`timescale 1ns / 1ps

module pez_edge #(
  parameter int unsigned CoordBits = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pez_pkg::edge_ctl_t          ctl_i,
  input  logic [2*CoordBits-1:0]      vtx_a_i,
  input  logic [2*CoordBits-1:0]      vtx_b_i,
  input  logic signed [CoordBits-1:0] qx_i,
  input  logic signed [CoordBits-1:0] qy_i,
  output pez_pkg::edge_sts_t          sts_o
);

  localparam int unsigned DW = CoordBits + 1;
  localparam int unsigned PW = 2 * DW;

  logic signed [CoordBits-1:0] ax, ay, bx, by;
  logic signed [DW-1:0]        dxq_d, dy_d, dxb_d, dyq_d;
  logic signed [DW-1:0]        dxq_q, dy_q, dxb_q, dyq_q;
  logic                        cross_d;
  logic                        s1_v_q, s1_last_q, s1_cross_q;
  logic signed [PW-1:0]        lhs_d, rhs_d, lhs_q, rhs_q;
  logic                        s2_v_q, s2_last_q, s2_cross_q, s2_dypos_q;
  logic                        toggle, parity_n;
  logic                        parity_q, inside_q;

  assign ax = $signed(vtx_a_i[CoordBits-1:0]);
  assign ay = $signed(vtx_a_i[2*CoordBits-1:CoordBits]);
  assign bx = $signed(vtx_b_i[CoordBits-1:0]);
  assign by = $signed(vtx_b_i[2*CoordBits-1:CoordBits]);

  assign cross_d = (ay > qy_i) != (by > qy_i);
  assign dxq_d   = $signed({qx_i[CoordBits-1], qx_i}) - $signed({ax[CoordBits-1], ax});
  assign dy_d    = $signed({by[CoordBits-1], by}) - $signed({ay[CoordBits-1], ay});
  assign dxb_d   = $signed({bx[CoordBits-1], bx}) - $signed({ax[CoordBits-1], ax});
  assign dyq_d   = $signed({qy_i[CoordBits-1], qy_i}) - $signed({ay[CoordBits-1], ay});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= ctl_i.issue;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_last_q  <= ctl_i.last;
    s1_cross_q <= cross_d;
    dxq_q      <= dxq_d;
    dy_q       <= dy_d;
    dxb_q      <= dxb_d;
    dyq_q      <= dyq_d;
  end

  assign lhs_d = dxq_q * dy_q;
  assign rhs_d = dxb_q * dyq_q;

  always_ff @(posedge clk_i) begin
    s2_last_q  <= s1_last_q;
    s2_cross_q <= s1_cross_q;
    s2_dypos_q <= ~dy_q[DW-1];
    lhs_q      <= lhs_d;
    rhs_q      <= rhs_d;
  end

  assign toggle   = s2_cross_q && (s2_dypos_q ? (lhs_q < rhs_q) : (lhs_q > rhs_q));
  assign parity_n = parity_q ^ toggle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_q <= 1'b0;
      inside_q <= 1'b0;
    end else if (ctl_i.clear) begin
      parity_q <= 1'b0;
      inside_q <= 1'b0;
    end else if (s2_v_q) begin
      if (s2_last_q) begin
        parity_q <= 1'b0;
        inside_q <= inside_q | parity_n;
      end else begin
        parity_q <= parity_n;
      end
    end
  end

  assign sts_o.busy = s1_v_q | s2_v_q;
  assign sts_o.hit  = inside_q;

endmodule

FILE: design/polygon_exclusion_zone_test.sv
// Top level: polygon table control, vertex walk and result register.
// Depends on pez_pkg, pez_ram and pez_edge.
//
//   channel  direction  signals                          word
//   in       input      in_valid_i, in_ready_o, in_data_i   pez_pkg::in_t
//   out      output     out_valid_o, out_ready_i, out_data_o pez_pkg::out_t
//
// Clear, append and close pass through accept, execute and post.
// A query reads one table entry per stored polygon, then its vertices, one
// vertex memory read per cycle; with no polygons it goes straight to post.
// Reset clears counts and control; memory contents stay undefined until written.
// One word is worked at a time; a new word is taken while the result waits.
`timescale 1ns / 1ps

module polygon_exclusion_zone_test #(
  parameter int unsigned MAX_VERTICES = 256,
  parameter int unsigned MAX_POLYGONS = 16,
  parameter int unsigned COORD_BITS   = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pez_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pez_pkg::out_t  out_data_o
);

  localparam int unsigned VFW  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned VAW  = $clog2(MAX_VERTICES);
  localparam int unsigned PCW  = $clog2(MAX_POLYGONS + 1);
  localparam int unsigned PAW  = (MAX_POLYGONS > 1) ? $clog2(MAX_POLYGONS) : 1;
  localparam int unsigned TotW = pez_pkg::TotalW;
  localparam int unsigned VW   = 2 * COORD_BITS;
  localparam int unsigned TW   = VAW + VFW;
  localparam int unsigned MinV = pez_pkg::MinPolyVerts;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_TRD   = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_POST  = 3'd5;

  logic [2:0]                   state_q, state_d;
  pez_pkg::mode_e               mode_q;
  logic signed [COORD_BITS-1:0] qx_q, qy_q;
  logic [VFW-1:0]               fill_q, fill_d, open_q, open_d;
  logic [PCW-1:0]               count_q, count_d;
  logic [PAW-1:0]               pidx_q, pidx_d, pidx_n;
  logic [VAW-1:0]               start_q, start_d;
  logic [VFW-1:0]               len_q, len_d, k_q, k_d;
  logic                         res_inside_q, res_inside_d;
  pez_pkg::status_e             res_status_q, res_status_d;
  logic                         out_valid_q;
  pez_pkg::out_t                out_q;
  logic                         out_load;

  logic                         rd_v_q, rd_prime_q, rd_last_q;
  logic                         rd_issue, rd_prime, rd_last;
  logic [VW-1:0]                prev_q;

  logic                         v_we;
  logic [VAW-1:0]               v_raddr;
  logic [VW-1:0]                v_wdata, v_rdata;
  logic                         p_we;
  logic [PAW-1:0]               p_raddr;
  logic [TW-1:0]                p_wdata, p_rdata;
  logic [VAW-1:0]               tbl_start;
  logic [VFW-1:0]               tbl_len, fill_less_open;

  pez_pkg::edge_ctl_t           e_ctl;
  pez_pkg::edge_sts_t           e_sts;

  assign in_ready_o = (state_q == S_IDLE);

  assign tbl_start      = p_rdata[VAW-1:0];
  assign tbl_len        = p_rdata[TW-1:VAW];
  assign fill_less_open = fill_q - open_q;
  assign pidx_n         = pidx_q + PAW'(1);

  assign v_wdata = {qy_q, qx_q};
  assign p_wdata = {open_q, fill_less_open[VAW-1:0]};

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    open_d       = open_q;
    count_d      = count_q;
    pidx_d       = pidx_q;
    start_d      = start_q;
    len_d        = len_q;
    k_d          = k_q;
    res_inside_d = res_inside_q;
    res_status_d = res_status_q;
    out_load     = 1'b0;
    v_we         = 1'b0;
    p_we         = 1'b0;
    v_raddr      = '0;
    p_raddr      = '0;
    rd_issue     = 1'b0;
    rd_prime     = 1'b0;
    rd_last      = 1'b0;
    e_ctl.clear  = 1'b0;
    e_ctl.issue  = rd_v_q && !rd_prime_q;
    e_ctl.last   = rd_last_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_inside_d = 1'b0;
        res_status_d = pez_pkg::ST_OK;
        state_d      = S_POST;
        unique case (mode_q)
          pez_pkg::MODE_CLEAR: begin
            count_d = '0;
            open_d  = '0;
            fill_d  = '0;
          end
          pez_pkg::MODE_APPEND: begin
            if (fill_q >= VFW'(MAX_VERTICES)) begin
              res_status_d = pez_pkg::ST_VTX_FULL;
            end else begin
              v_we   = 1'b1;
              fill_d = fill_q + VFW'(1);
              open_d = open_q + VFW'(1);
            end
          end
          pez_pkg::MODE_CLOSE: begin
            if (open_q < VFW'(MinV)) begin
              res_status_d = pez_pkg::ST_DISCARD;
              fill_d       = fill_less_open;
            end else if (count_q >= PCW'(MAX_POLYGONS)) begin
              res_status_d = pez_pkg::ST_TBL_FULL;
              fill_d       = fill_less_open;
            end else begin
              p_we    = 1'b1;
              count_d = count_q + PCW'(1);
            end
            open_d = '0;
          end
          pez_pkg::MODE_QUERY: begin
            e_ctl.clear = 1'b1;
            if (count_q != '0) begin
              pidx_d  = '0;
              state_d = S_TRD;
            end
          end
          default: begin
            state_d = S_POST;
          end
        endcase
      end
      S_TRD: begin
        start_d  = tbl_start;
        len_d    = tbl_len;
        k_d      = '0;
        v_raddr  = VAW'(VFW'(tbl_start) + tbl_len - VFW'(1));
        rd_issue = 1'b1;
        rd_prime = 1'b1;
        state_d  = S_WALK;
      end
      S_WALK: begin
        v_raddr  = VAW'(VFW'(start_q) + k_q);
        rd_issue = 1'b1;
        if (k_q == len_q - VFW'(1)) begin
          rd_last = 1'b1;
          if (PCW'(pidx_q) + PCW'(1) < count_q) begin
            pidx_d  = pidx_n;
            p_raddr = pidx_n;
            state_d = S_TRD;
          end else begin
            state_d = S_DRAIN;
          end
        end else begin
          k_d = k_q + VFW'(1);
        end
      end
      S_DRAIN: begin
        if (!rd_v_q && !e_sts.busy) begin
          res_inside_d = e_sts.hit;
          state_d      = S_POST;
        end
      end
      S_POST: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      open_q      <= '0;
      count_q     <= '0;
      pidx_q      <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      rd_v_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      open_q  <= open_d;
      count_q <= count_d;
      pidx_q  <= pidx_d;
      k_q     <= k_d;
      rd_v_q  <= rd_issue;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mode_q <= in_data_i.mode;
      qx_q   <= in_data_i.coord_x[COORD_BITS-1:0];
      qy_q   <= in_data_i.coord_y[COORD_BITS-1:0];
    end
    start_q      <= start_d;
    len_q        <= len_d;
    res_inside_q <= res_inside_d;
    res_status_q <= res_status_d;
    rd_prime_q   <= rd_prime;
    rd_last_q    <= rd_last;
    if (rd_v_q) begin
      prev_q <= v_rdata;
    end
    if (out_load) begin
      out_q.inside_res    <= res_inside_q;
      out_q.status        <= res_status_q;
      out_q.polygon_total <= TotW'(count_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  pez_ram #(
    .Width (VW),
    .Depth (MAX_VERTICES)
  ) u_vtx_ram (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (fill_q[VAW-1:0]),
    .wdata_i (v_wdata),
    .raddr_i (v_raddr),
    .rdata_o (v_rdata)
  );

  pez_ram #(
    .Width (TW),
    .Depth (MAX_POLYGONS)
  ) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (count_q[PAW-1:0]),
    .wdata_i (p_wdata),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  pez_edge #(
    .CoordBits (COORD_BITS)
  ) u_edge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (e_ctl),
    .vtx_a_i (v_rdata),
    .vtx_b_i (prev_q),
    .qx_i    (qx_q),
    .qy_i    (qy_q),
    .sts_o   (e_sts)
  );

endmodule

FILE: test/polygon_exclusion_zone_test_test.sv
// Testbench for polygon_exclusion_zone_test: a directed table, then random polygon
// builds, queries and noise, checked against fixed answers or an in-bench predictor.
// Depends on pez_pkg and the design; drives valid/ready on both channels.
`timescale 1ns / 1ps

module polygon_exclusion_zone_test_test;

  localparam int unsigned HalfPeriod   = 10;
  localparam int unsigned MaxVerts     = 256;
  localparam int unsigned MaxPolys     = 16;
  localparam int unsigned RandItems    = 1420;
  localparam int unsigned RxHoldCycles = 400;
  localparam int unsigned HoldAt       = 500;
  localparam int unsigned PauseAt      = 900;
  localparam int unsigned WatchLimit   = 5000;
  localparam int unsigned DrainCycles  = 20;
  localparam logic signed [31:0] CMin  = 32'sh8000_0000;
  localparam logic signed [31:0] CMax  = 32'sh7fff_ffff;

  typedef struct {
    pez_pkg::in_t  word;
    bit            known;
    pez_pkg::out_t answer;
  } script_row_t;

  logic           clk = 1'b0;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  pez_pkg::in_t   in_data;
  logic           out_valid;
  logic           out_ready;
  pez_pkg::out_t  out_data;

  pez_pkg::out_t answer_q[$];
  int unsigned   errors = 0;
  int unsigned   sent = 0;
  bit            calm = 1'b0;
  bit            rx_hold_req = 1'b0;
  bit            pause_req = 1'b0;

  logic signed [31:0] zone_vx[MaxVerts];
  logic signed [31:0] zone_vy[MaxVerts];
  int unsigned        zone_base[MaxPolys];
  int unsigned        zone_len[MaxPolys];
  int unsigned        zone_count = 0;
  int unsigned        open_count = 0;
  int unsigned        fill_count = 0;

  logic signed [31:0] last_x[$];
  logic signed [31:0] last_y[$];

  always #(HalfPeriod) clk = ~clk;

  polygon_exclusion_zone_test #(
    .MAX_VERTICES(MaxVerts),
    .MAX_POLYGONS(MaxPolys),
    .COORD_BITS  (32)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  function automatic bit zone_holds(int unsigned base, int unsigned len,
                                    logic signed [31:0] qx, logic signed [31:0] qy);
    bit                 odd;
    int unsigned        i, j;
    logic signed [31:0] ax, ay, bx, by;
    logic signed [32:0] dy;
    logic signed [67:0] lhs, rhs;
    odd = 1'b0;
    j = len - 1;
    for (i = 0; i < len; i++) begin
      ax = zone_vx[base + i];
      ay = zone_vy[base + i];
      bx = zone_vx[base + j];
      by = zone_vy[base + j];
      if ((ay > qy) != (by > qy)) begin
        dy  = by - ay;
        lhs = (qx - ax) * dy;
        rhs = (bx - ax) * (qy - ay);
        if ((dy > 0 && lhs < rhs) || (dy < 0 && lhs > rhs)) odd = !odd;
      end
      j = i;
    end
    return odd;
  endfunction

  function automatic pez_pkg::out_t zone_step(pez_pkg::in_t w);
    pez_pkg::out_t r;
    r = '0;
    case (w.mode)
      pez_pkg::MODE_CLEAR: begin
        zone_count = 0;
        open_count = 0;
        fill_count = 0;
      end
      pez_pkg::MODE_APPEND: begin
        if (fill_count >= MaxVerts) begin
          r.status = pez_pkg::ST_VTX_FULL;
        end else begin
          zone_vx[fill_count] = w.coord_x;
          zone_vy[fill_count] = w.coord_y;
          fill_count++;
          open_count++;
        end
      end
      pez_pkg::MODE_CLOSE: begin
        if (open_count > fill_count) open_count = fill_count;
        if (open_count < pez_pkg::MinPolyVerts) begin
          r.status = pez_pkg::ST_DISCARD;
          fill_count -= open_count;
        end else if (zone_count >= MaxPolys) begin
          r.status = pez_pkg::ST_TBL_FULL;
          fill_count -= open_count;
        end else begin
          zone_base[zone_count] = fill_count - open_count;
          zone_len[zone_count]  = open_count;
          zone_count++;
        end
        open_count = 0;
      end
      default: begin
        for (int unsigned p = 0; p < zone_count; p++) begin
          if (zone_holds(zone_base[p], zone_len[p], w.coord_x, w.coord_y)) begin
            r.inside_res = 1'b1;
            break;
          end
        end
      end
    endcase
    r.polygon_total = 5'(zone_count);
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [31:0] near(logic signed [31:0] c, int unsigned span);
    return c + 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  function automatic script_row_t model_row(pez_pkg::mode_e m, logic signed [31:0] x,
                                            logic signed [31:0] y);
    script_row_t r;
    r.word   = '{mode: m, coord_x: x, coord_y: y};
    r.known  = 1'b0;
    r.answer = '0;
    return r;
  endfunction

  function automatic script_row_t known_row(pez_pkg::mode_e m, logic signed [31:0] x,
                                            logic signed [31:0] y, logic ins,
                                            pez_pkg::status_e st, int unsigned tot);
    script_row_t r;
    r.word   = '{mode: m, coord_x: x, coord_y: y};
    r.known  = 1'b1;
    r.answer = '{inside_res: ins, status: st, polygon_total: 5'(tot)};
    return r;
  endfunction

  task automatic sender_idle();
    int unsigned g;
    g = pick_gap();
    if (pause_req) begin
      in_valid <= 1'b0;
      wait (answer_q.size() == 0);
      @(negedge clk);
      pause_req = 1'b0;
    end else if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic send_word(pez_pkg::in_t w, bit known, pez_pkg::out_t fixed_ans);
    pez_pkg::out_t predicted;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    predicted = zone_step(w);
    answer_q = {answer_q, (known ? fixed_ans : predicted)};
    sent++;
    @(negedge clk);
    sender_idle();
  endtask

  task automatic offer(pez_pkg::mode_e m, logic signed [31:0] x, logic signed [31:0] y);
    send_word('{mode: m, coord_x: x, coord_y: y}, 1'b0, '0);
  endtask

  task automatic build_zone(int unsigned n, logic signed [31:0] cx, logic signed [31:0] cy,
                            int unsigned span);
    logic signed [31:0] x, y;
    last_x.delete();
    last_y.delete();
    repeat (n) begin
      x = near(cx, span);
      y = near(cy, span);
      last_x = {last_x, x};
      last_y = {last_y, y};
      offer(pez_pkg::MODE_APPEND, x, y);
    end
    offer(pez_pkg::MODE_CLOSE, $urandom, $urandom);
  endtask

  task automatic probe(int unsigned k, logic signed [31:0] cx, logic signed [31:0] cy,
                       int unsigned span);
    logic signed [31:0] x, y;
    int unsigned        r, v;
    repeat (k) begin
      r = $urandom_range(0, 9);
      if (r < 2 && last_x.size() > 0) begin
        v = $urandom_range(0, last_x.size() - 1);
        x = last_x[v];
        y = last_y[v];
        if (r == 1) x = near(x, 2);
      end else if (r == 2) begin
        x = $urandom;
        y = $urandom;
      end else begin
        x = near(cx, span + span / 4);
        y = near(cy, span + span / 4);
      end
      offer(pez_pkg::MODE_QUERY, x, y);
    end
  endtask

  initial begin : stimulus
    script_row_t        script[$];
    logic signed [31:0] cx, cy;
    int unsigned        span, ep, r, n, target;
    bit                 hold_done, pause_done;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    cx = 0;
    cy = 0;
    span = 1000;
    hold_done = 1'b0;
    pause_done = 1'b0;

    script = {script, known_row(pez_pkg::MODE_QUERY,  0, 0, 1'b0, pez_pkg::ST_OK, 0)};
    script = {script, known_row(pez_pkg::MODE_CLOSE,  0, 0, 1'b0, pez_pkg::ST_DISCARD, 0)};
    script = {script, known_row(pez_pkg::MODE_APPEND, 5, 5, 1'b0, pez_pkg::ST_OK, 0)};
    script = {script, known_row(pez_pkg::MODE_APPEND, -5, 5, 1'b0, pez_pkg::ST_OK, 0)};
    script = {script, known_row(pez_pkg::MODE_CLOSE, CMax, CMin, 1'b0,
                                pez_pkg::ST_DISCARD, 0)};
    script = {script, known_row(pez_pkg::MODE_APPEND, CMin, CMin, 1'b0, pez_pkg::ST_OK, 0)};
    script = {script, known_row(pez_pkg::MODE_APPEND, CMax, CMin, 1'b0, pez_pkg::ST_OK, 0)};
    script = {script, known_row(pez_pkg::MODE_APPEND, CMax, CMax, 1'b0, pez_pkg::ST_OK, 0)};
    script = {script, known_row(pez_pkg::MODE_APPEND, CMin, CMax, 1'b0, pez_pkg::ST_OK, 0)};
    script = {script, known_row(pez_pkg::MODE_CLOSE,  0, 0, 1'b0, pez_pkg::ST_OK, 1)};
    script = {script, known_row(pez_pkg::MODE_QUERY,  0, 0, 1'b1, pez_pkg::ST_OK, 1)};
    script = {script, model_row(pez_pkg::MODE_QUERY,  CMin, CMin)};
    script = {script, model_row(pez_pkg::MODE_QUERY,  CMax, CMax)};
    script = {script, model_row(pez_pkg::MODE_QUERY,  CMax, -1)};
    script = {script, model_row(pez_pkg::MODE_QUERY,  CMin, 0)};
    script = {script, known_row(pez_pkg::MODE_CLEAR, CMin, CMax, 1'b0, pez_pkg::ST_OK, 0)};
    script = {script, known_row(pez_pkg::MODE_QUERY,  0, 0, 1'b0, pez_pkg::ST_OK, 0)};
    script = {script, known_row(pez_pkg::MODE_APPEND, 0, 0, 1'b0, pez_pkg::ST_OK, 0)};
    script = {script, known_row(pez_pkg::MODE_APPEND, 100, 0, 1'b0, pez_pkg::ST_OK, 0)};
    script = {script, known_row(pez_pkg::MODE_APPEND, 0, 100, 1'b0, pez_pkg::ST_OK, 0)};
    script = {script, known_row(pez_pkg::MODE_CLOSE,  0, 0, 1'b0, pez_pkg::ST_OK, 1)};
    script = {script, known_row(pez_pkg::MODE_QUERY,  10, 10, 1'b1, pez_pkg::ST_OK, 1)};
    script = {script, known_row(pez_pkg::MODE_QUERY,  60, 60, 1'b0, pez_pkg::ST_OK, 1)};
    script = {script, model_row(pez_pkg::MODE_QUERY,  50, 50)};
    script = {script, model_row(pez_pkg::MODE_QUERY,  0, 50)};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (script[i]) send_word(script[i].word, script[i].known, script[i].answer);

    target = sent + RandItems;
    ep = 0;
    while (sent < target) begin
      calm = ($urandom_range(0, 5) == 0);
      if (!hold_done && sent >= HoldAt) begin
        rx_hold_req = 1'b1;
        hold_done = 1'b1;
      end
      if (!pause_done && sent >= PauseAt) begin
        pause_req = 1'b1;
        pause_done = 1'b1;
      end
      r = $urandom_range(0, 9);
      if (r < 5) begin
        cx = near(0, 2000);
        cy = near(0, 2000);
        span = $urandom_range(10, 1000);
      end else if (r < 8) begin
        cx = $urandom;
        cy = $urandom;
        span = $urandom_range(1000, 1 << 20);
      end else begin
        cx = $urandom;
        cy = $urandom;
        span = 1 << 30;
      end
      if (ep == 0) begin
        offer(pez_pkg::MODE_CLEAR, 0, 0);
        build_zone(MaxVerts + 4, 0, 0, 10000);
        probe(12, 0, 0, 10000);
      end else if (ep == 1) begin
        offer(pez_pkg::MODE_CLEAR, 0, 0);
        repeat (MaxPolys + 2) build_zone(3, cx, cy, span);
        probe(8, cx, cy, span);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          offer(pez_pkg::MODE_CLEAR, $urandom, $urandom);
        end else if (r < 55) begin
          n = $urandom_range(0, 99);
          if (n < 8) n = $urandom_range(0, 2);
          else if (n < 95) n = $urandom_range(3, 10);
          else n = $urandom_range(11, 60);
          build_zone(n, cx, cy, span);
          probe($urandom_range(1, 6), cx, cy, span);
        end else if (r < 57) begin
          build_zone($urandom_range(100, MaxVerts + 10), cx, cy, span);
          probe($urandom_range(1, 4), cx, cy, span);
        end else if (r < 85) begin
          probe($urandom_range(1, 8), cx, cy, span);
        end else begin
          repeat ($urandom_range(1, 4)) begin
            offer(pez_pkg::mode_e'($urandom_range(0, 3)), $urandom, $urandom);
          end
        end
      end
      ep++;
    end

    in_valid <= 1'b0;
    wait (answer_q.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) $display("polygon_exclusion_zone_test verification clean");
    else $display("polygon_exclusion_zone_test verification failed");
    $finish;
  end

  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        repeat (RxHoldCycles) @(negedge clk);
        rx_hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    pez_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (answer_q.size() == 0) begin
        $error("result word with nothing pending: %h", out_data);
        errors++;
      end else begin
        want = answer_q.pop_front();
        if (out_data.inside_res !== want.inside_res) begin
          $error("inside_res: expected %0d, got %0d", want.inside_res, out_data.inside_res);
          errors++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          errors++;
        end
        if (out_data.polygon_total !== want.polygon_total) begin
          $error("polygon_total: expected %0d, got %0d", want.polygon_total,
                 out_data.polygon_total);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    do begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end while (quiet < WatchLimit);
    $display("polygon_exclusion_zone_test verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
design/pez_pkg.sv
design/pez_ram.sv
design/pez_edge.sv
design/polygon_exclusion_zone_test.sv
test/polygon_exclusion_zone_test_test.sv
